// File: hdl/cfsb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the convective flux unit (superbee limiter).
// No dependencies; imported by every module of the block.
package cfsb_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_X_FACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_Y_FACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_Z_FACE = 3'd4;

    // axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0]  DIMS_RESET = 2'd3;
    localparam logic [31:0] AREA_RESET = 32'h0001_0000;   // 1.0 in Q16.16

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [1:0]         axis;
        logic [1:0]         boundary_side;
        logic signed [31:0] phi_minus2;
        logic signed [31:0] phi_minus1;
        logic signed [31:0] phi_center;
        logic signed [31:0] phi_plus1;
        logic signed [31:0] phi_plus2;
        logic signed [31:0] vel_low_face;
        logic signed [31:0] vel_high_face;
        logic signed [31:0] den_minus1;
        logic signed [31:0] den_center;
        logic signed [31:0] den_plus1;
    } cfsb_in_t;

    typedef struct packed {
        logic signed [63:0] conv_term;
        logic               saturated;
    } cfsb_out_t;

    // one face after upwind selection
    typedef struct packed {
        logic               plain;   // face value is sup, no limiter
        logic signed [31:0] sup;     // upstream value (0 for still face)
        logic signed [32:0] d;       // downstream - upstream
        logic signed [32:0] nd;      // upstream - far
    } cfsb_face_t;

    typedef struct packed {
        logic               first;
        logic               last;
        logic [31:0]        area;
        cfsb_face_t         face_hi;
        cfsb_face_t         face_lo;
        logic signed [31:0] vel_hi;
        logic signed [31:0] vel_lo;
        logic signed [31:0] dens_hi;
        logic signed [31:0] dens_lo;
    } cfsb_job_t;

endpackage

// File: hdl/cfsb_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance, upwind classification.
// Depends on cfsb_pkg.
module cfsb_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cfsb_pkg::cfsb_in_t                  s_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output cfsb_pkg::cfsb_job_t                 q_data
);
    import cfsb_pkg::*;

    logic        scheme_mode_reg;
    logic [1:0]  dims_reg;
    logic [31:0] area_x_reg;
    logic [31:0] area_y_reg;
    logic [31:0] area_z_reg;

    logic [1:0]  last_axis;
    logic        lim_lo;
    logic        lim_hi;
    logic signed [32:0] dsum_hi;
    logic signed [32:0] dsum_lo;

    function automatic cfsb_face_t pick_face(
        input logic signed [31:0] vel,
        input logic               lim,
        input logic signed [31:0] sup_p,
        input logic signed [31:0] sdn_p,
        input logic signed [31:0] far_p,
        input logic signed [31:0] sup_n,
        input logic signed [31:0] sdn_n,
        input logic signed [31:0] far_n
    );
        cfsb_face_t         f;
        logic signed [31:0] sup;
        logic signed [31:0] sdn;
        logic signed [31:0] far;
        if (vel < 0) begin
            sup = sup_n;
            sdn = sdn_n;
            far = far_n;
        end else begin
            sup = sup_p;
            sdn = sdn_p;
            far = far_p;
        end
        f.d     = {sdn[31], sdn} - {sup[31], sup};
        f.nd    = {sup[31], sup} - {far[31], far};
        f.sup   = (vel == 0) ? '0 : sup;
        f.plain = !lim || (f.d == '0) || (vel == 0);
        return f;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_mode_reg <= 1'b0;
            dims_reg        <= DIMS_RESET;
            area_x_reg      <= AREA_RESET;
            area_y_reg      <= AREA_RESET;
            area_z_reg      <= AREA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCHEME_MODE: scheme_mode_reg <= cfg_data[0];
                CFG_DIMS_IN_USE: dims_reg        <= cfg_data[1:0];
                CFG_AREA_X_FACE: area_x_reg      <= cfg_data;
                CFG_AREA_Y_FACE: area_y_reg      <= cfg_data;
                CFG_AREA_Z_FACE: area_z_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // boundary_side bit 0 forces the low face upwind, bit 1 the high face
    assign lim_lo    = scheme_mode_reg && !s_data.boundary_side[0];
    assign lim_hi    = scheme_mode_reg && !s_data.boundary_side[1];
    assign last_axis = (dims_reg == 2'd0) ? 2'd0 : dims_reg - 2'd1;
    assign dsum_hi   = {s_data.den_center[31], s_data.den_center}
                     + {s_data.den_plus1[31], s_data.den_plus1};
    assign dsum_lo   = {s_data.den_center[31], s_data.den_center}
                     + {s_data.den_minus1[31], s_data.den_minus1};

    always_comb begin
        q_data.first = (s_data.axis == AXIS_X);
        q_data.last  = (s_data.axis == last_axis);
        unique case (s_data.axis)
            AXIS_X:  q_data.area = area_x_reg;
            AXIS_Y:  q_data.area = area_y_reg;
            default: q_data.area = area_z_reg;
        endcase
        q_data.face_hi = pick_face(s_data.vel_high_face, lim_hi,
                                   s_data.phi_center, s_data.phi_plus1, s_data.phi_minus1,
                                   s_data.phi_plus1, s_data.phi_center, s_data.phi_plus2);
        q_data.face_lo = pick_face(s_data.vel_low_face, lim_lo,
                                   s_data.phi_minus1, s_data.phi_center, s_data.phi_minus2,
                                   s_data.phi_center, s_data.phi_minus1, s_data.phi_plus1);
        q_data.vel_hi  = s_data.vel_high_face;
        q_data.vel_lo  = s_data.vel_low_face;
        q_data.dens_hi = dsum_hi[32:1];   // floor of the mean
        q_data.dens_lo = dsum_lo[32:1];
    end

    assign s_ready = !q_full;
    // axis 3 is taken and dropped
    assign q_push  = s_valid && !q_full && (s_data.axis != AXIS_NONE);

endmodule

// File: hdl/cfsb_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on cfsb_pkg; DEPTH of 2 or more.
module cfsb_queue #(
    parameter int unsigned DEPTH = cfsb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cfsb_pkg::cfsb_job_t push_data,
    output logic                full,
    input  logic                pop,
    output cfsb_pkg::cfsb_job_t pop_data,
    output logic                empty
);
    import cfsb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cfsb_job_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/cfsb_back.sv
`timescale 1ns / 1ps
// Back end: sequencer with a bit-serial limiter divider, a shared split
// multiplier, saturating accumulation and the result register. Depends on cfsb_pkg.
module cfsb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  cfsb_pkg::cfsb_job_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cfsb_pkg::cfsb_out_t m_data
);
    import cfsb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIV, S_PSI, S_FACE, S_MSET, S_MLO, S_MHI,
        S_MFIN, S_NEXT, S_SUB, S_ACC, S_OUT
    } state_t;

    typedef enum logic [1:0] {MS_DENS, MS_VEL, MS_AREA} mstep_t;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic [18:0]        PSI_ONE = 19'd65536;
    localparam logic [17:0]        PSI_MAX = 18'd131072;
    localparam logic [4:0]         DIV_LAST = 5'd17;

    state_t             state_reg;
    mstep_t             mstep_reg;
    cfsb_job_t          job_reg;
    logic               lo_side_reg;
    logic [32:0]        den_reg;
    logic               neg_r_reg;
    logic [32:0]        rem_reg;
    logic [17:0]        qn_reg;
    logic [4:0]         cnt_reg;
    logic signed [51:0] prod_reg;
    logic signed [34:0] face_reg;
    logic [63:0]        ma_reg;
    logic [31:0]        mb_reg;
    logic               mneg_reg;
    logic [95:0]        macc_reg;
    logic signed [63:0] mres_reg;
    logic signed [63:0] flux_hi_reg;
    logic signed [63:0] acc_reg;
    logic               sticky_reg;
    logic               m_valid_reg;
    cfsb_out_t          m_data_reg;

    cfsb_face_t         cur_face;
    logic signed [31:0] cur_dens;
    logic signed [31:0] cur_vel;
    logic [32:0]        nd_mag;
    logic [32:0]        d_mag;
    logic               div_ovf;
    logic [33:0]        rem_sh;
    logic [33:0]        rem_sub;
    logic               rem_ge;
    logic [32:0]        rem_next;
    logic [17:0]        qn_next;
    logic [18:0]        lim_a;
    logic [17:0]        lim_b;
    logic [17:0]        psi;
    logic signed [51:0] prod;
    logic signed [34:0] face_sum;
    logic signed [63:0] set_a;
    logic signed [32:0] set_b;
    logic [32:0]        set_bmag;
    logic               set_neg;
    logic [63:0]        set_ma;
    logic [31:0]        mul_x;
    logic [63:0]        mul_p;
    logic               frac;
    logic [79:0]        q80;
    logic               mul_over;
    logic signed [63:0] mul_res;
    logic signed [63:0] diff;
    logic               sub_over;
    logic signed [63:0] sum;
    logic               add_over;
    logic               out_free;

    assign cur_face = lo_side_reg ? job_reg.face_lo : job_reg.face_hi;
    assign cur_dens = lo_side_reg ? job_reg.dens_lo : job_reg.dens_hi;
    assign cur_vel  = lo_side_reg ? job_reg.vel_lo  : job_reg.vel_hi;

    // limiter ratio: |nd|*2^16 / |d|; quotients of 2^18 and up clamp psi at 2.0
    assign nd_mag  = cur_face.nd[32] ? (~cur_face.nd + 33'd1) : cur_face.nd;
    assign d_mag   = cur_face.d[32]  ? (~cur_face.d  + 33'd1) : cur_face.d;
    assign div_ovf = ({2'b00, nd_mag} >= {d_mag, 2'b00});

    assign rem_sh   = {rem_reg, qn_reg[17]};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_next = rem_ge ? rem_sub[32:0] : rem_sh[32:0];
    assign qn_next  = {qn_reg[16:0], rem_ge};

    // psi = max(min(2r, 1), min(r, 2)), zero for r <= 0
    always_comb begin
        lim_a = ({qn_reg, 1'b0} < PSI_ONE) ? {qn_reg, 1'b0} : PSI_ONE;
        lim_b = (qn_reg < PSI_MAX) ? qn_reg : PSI_MAX;
        if (neg_r_reg || (qn_reg == '0)) begin
            psi = '0;
        end else if (lim_a > {1'b0, lim_b}) begin
            psi = lim_a[17:0];
        end else begin
            psi = lim_b;
        end
    end

    assign prod     = $signed({1'b0, psi}) * cur_face.d;
    assign face_sum = {{3{cur_face.sup[31]}}, cur_face.sup} + prod_reg[51:17];

    // operand selection and sign/magnitude split for the shared multiplier
    always_comb begin
        priority case (state_reg)
            S_MSET: begin
                set_a = {{29{face_reg[34]}}, face_reg};
                set_b = {cur_dens[31], cur_dens};
            end
            S_NEXT: begin
                set_a = mres_reg;
                set_b = {cur_vel[31], cur_vel};
            end
            default: begin
                set_a = diff;
                set_b = {1'b0, job_reg.area};
            end
        endcase
        set_neg  = set_a[63] ^ set_b[32];
        set_ma   = set_a[63] ? (~set_a + 64'd1) : set_a;
        set_bmag = set_b[32] ? (~set_b + 33'd1) : set_b;
    end

    assign mul_x = (state_reg == S_MHI) ? ma_reg[63:32] : ma_reg[31:0];
    assign mul_p = mul_x * mb_reg;

    // floor(product / 2^16), saturated to 64 bits signed
    assign frac = mneg_reg && (macc_reg[15:0] != '0);
    assign q80  = macc_reg[95:16] + {79'd0, frac};
    always_comb begin
        if (mneg_reg) begin
            mul_over = (q80[79:64] != '0) || (q80[63] && (q80[62:0] != '0));
            mul_res  = mul_over ? S64_MIN : (~q80[63:0] + 64'd1);
        end else begin
            mul_over = (q80[79:63] != '0);
            mul_res  = mul_over ? S64_MAX : q80[63:0];
        end
    end

    assign diff     = flux_hi_reg - mres_reg;
    assign sub_over = (flux_hi_reg[63] != mres_reg[63]) && (diff[63] != flux_hi_reg[63]);
    assign sum      = acc_reg + mres_reg;
    assign add_over = (acc_reg[63] == mres_reg[63]) && (sum[63] != acc_reg[63]);

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mstep_reg   <= MS_DENS;
            lo_side_reg <= 1'b0;
            acc_reg     <= '0;
            sticky_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // the output step reloads the register itself when the old result leaves
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        job_reg     <= q_data;
                        lo_side_reg <= 1'b0;
                        if (q_data.first) begin
                            acc_reg    <= '0;
                            sticky_reg <= 1'b0;
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (cur_face.plain) begin
                        face_reg  <= {{3{cur_face.sup[31]}}, cur_face.sup};
                        state_reg <= S_MSET;
                    end else begin
                        den_reg   <= d_mag;
                        neg_r_reg <= cur_face.nd[32] ^ cur_face.d[32];
                        rem_reg   <= {2'b00, nd_mag[32:2]};
                        qn_reg    <= div_ovf ? '1 : {nd_mag[1:0], 16'd0};
                        cnt_reg   <= DIV_LAST;
                        state_reg <= div_ovf ? S_PSI : S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    qn_reg  <= qn_next;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_PSI;
                    end
                end
                S_PSI: begin
                    prod_reg  <= prod;
                    state_reg <= S_FACE;
                end
                S_FACE: begin
                    face_reg  <= face_sum;
                    state_reg <= S_MSET;
                end
                S_MSET: begin
                    ma_reg    <= set_ma;
                    mb_reg    <= set_bmag[31:0];
                    mneg_reg  <= set_neg;
                    mstep_reg <= MS_DENS;
                    state_reg <= S_MLO;
                end
                S_MLO: begin
                    macc_reg  <= {32'd0, mul_p};
                    state_reg <= S_MHI;
                end
                S_MHI: begin
                    macc_reg  <= macc_reg + {mul_p, 32'd0};
                    state_reg <= S_MFIN;
                end
                S_MFIN: begin
                    mres_reg  <= mul_res;
                    if (mul_over) begin
                        sticky_reg <= 1'b1;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    unique case (mstep_reg)
                        MS_DENS: begin
                            ma_reg    <= set_ma;
                            mb_reg    <= set_bmag[31:0];
                            mneg_reg  <= set_neg;
                            mstep_reg <= MS_VEL;
                            state_reg <= S_MLO;
                        end
                        MS_VEL: begin
                            if (!lo_side_reg) begin
                                flux_hi_reg <= mres_reg;
                                lo_side_reg <= 1'b1;
                                state_reg   <= S_PREP;
                            end else begin
                                state_reg <= S_SUB;
                            end
                        end
                        default: begin
                            state_reg <= S_ACC;
                        end
                    endcase
                end
                S_SUB: begin
                    // area * saturated(high - low); diff feeds the setup path
                    if (sub_over) begin
                        sticky_reg <= 1'b1;
                    end
                    ma_reg    <= sub_over ? (flux_hi_reg[63] ? 64'(S64_MIN) : 64'(S64_MAX))
                                          : set_ma;
                    mb_reg    <= set_bmag[31:0];
                    mneg_reg  <= sub_over ? flux_hi_reg[63] : set_neg;
                    mstep_reg <= MS_AREA;
                    state_reg <= S_MLO;
                end
                S_ACC: begin
                    if (add_over) begin
                        sticky_reg <= 1'b1;
                        acc_reg    <= acc_reg[63] ? S64_MIN : S64_MAX;
                    end else begin
                        acc_reg <= sum;
                    end
                    state_reg <= job_reg.last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.conv_term <= acc_reg;
                        m_data_reg.saturated <= sticky_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> cnt_reg <= DIV_LAST)
        else $error("divider step count out of range");

    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !q_empty && q_data.first) |=>
            (acc_reg == '0 && !sticky_reg))
        else $error("first axis did not clear the accumulator");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_psi_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PSI |-> psi <= PSI_MAX)
        else $error("limiter psi above 2.0");

endmodule

// File: hdl/convective_flux_superbee_unit.sv
`timescale 1ns / 1ps
// Top level of the convective flux unit with superbee limiter.
// Depends on cfsb_pkg, cfsb_front, cfsb_queue and cfsb_back.
//
//  channel  ports                              carries
//  s_       s_valid / s_ready / s_data         one axis request of one cell
//  m_       m_valid / m_ready / m_data         cell convection term + sat flag
//  cfg_     cfg_valid / cfg_ready / cfg_index  register write, cfg_data payload
//
// Sequence: the back end handles one request at a time, with limited faces going
//   through the one-bit-per-cycle restoring divider, and adds a result step on the
//   last axis. The back-end sequencer with its single 32x32 multiplier, used in two
//   halves, sets the pace of the unit.
// Reset: aresetn synchronous, active low; clears config to defaults, the queue,
//   the accumulator and the saturation flag. No clearing pass.
// Stalls: the front takes requests while the queue has room; the back holds a
//   finished result in its output register and waits only when another is due.
module convective_flux_superbee_unit #(
    parameter int unsigned QUEUE_DEPTH = cfsb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cfsb_pkg::cfsb_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cfsb_pkg::cfsb_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import cfsb_pkg::*;

    // front -> queue
    logic      q_push;
    logic      q_full;
    cfsb_job_t q_in;
    // queue -> back
    logic      q_pop;
    logic      q_empty;
    cfsb_job_t q_out;

    // Front: config registers, accept, upwind selection, densities, area pick.
    cfsb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Queue decouples classification from the long arithmetic sequence.
    cfsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back: limiter division, flux products, accumulation, result register.
    cfsb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_out),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
